### rtl/unique_random_draw_pool_unit_defines.svh
// assertion macros shared by the pool draw modules
// expects clk and arst_n in the scope of each use
`ifndef UNIQUE_RANDOM_DRAW_POOL_UNIT_DEFINES_SVH
`define UNIQUE_RANDOM_DRAW_POOL_UNIT_DEFINES_SVH

// same-cycle implication
`define URDP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define URDP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/urdp_pkg.sv
// shared widths, codes and controller/datapath interface structs
// no dependencies
`default_nettype none

package urdp_pkg;

	localparam int RND_W   = 31;
	localparam int DRAWN_W = 12;
	localparam int CFG_W   = 13;
	localparam int DIVC_W  = $clog2(RND_W);

	localparam logic CMD_RESTART = 1'b0;
	localparam logic CMD_DRAW    = 1'b1;

	typedef struct packed {
		logic load_in;
		logic restart;
		logic fill_step;
		logic fill_end;
		logic div_start;
		logic div_step;
		logic rd_slot;
		logic rd_last;
		logic swap;
		logic out_load;
		logic out_exh;
	} urdp_cmd_t;

	typedef struct packed {
		logic fill_done;
		logic count_zero;
		logic div_last;
		logic out_busy;
	} urdp_sts_t;

endpackage

`default_nettype wire

### rtl/urdp_datapath.sv
// datapath: pool memory, remaining count, serial modulo unit, result register
// depends on urdp_pkg and the assertion macro header
`default_nettype none
`include "unique_random_draw_pool_unit_defines.svh"

module urdp_datapath import urdp_pkg::*; #(
	parameter int POOL_DEPTH = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [CFG_W-1:0]   cfg_wr_data,
	input  wire logic               cfg_wr_en,
	input  wire logic [RND_W-1:0]   random_value,
	input  wire urdp_cmd_t          cmd,
	output urdp_sts_t               sts,
	input  wire logic               m_ready,
	output logic                    m_valid,
	output logic [DRAWN_W-1:0]      drawn_number,
	output logic                    exhausted
);

	localparam int AW = $clog2(POOL_DEPTH);
	localparam int CW = $clog2(POOL_DEPTH + 1);
	localparam int SW = (CW > CFG_W) ? CW : CFG_W;

	logic [CFG_W-1:0]  set_size_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     fill_cnt_q;
	logic [RND_W-1:0]  dividend_q;
	logic [CW-1:0]     rem_q;
	logic [DIVC_W-1:0] div_cnt_q;
	logic [AW-1:0]     mem [POOL_DEPTH];
	logic [AW-1:0]     rd_data_q;
	logic [AW-1:0]     drawn_q;
	logic              out_valid_q;
	logic [DRAWN_W-1:0] out_drawn_q;
	logic              out_exh_q;

	logic [SW-1:0]     size_ext;
	logic [CW-1:0]     fill_n;
	logic [CW-1:0]     last_cnt;
	logic [CW:0]       trial;
	logic              trial_ge;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [AW-1:0]     mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;

	// saturate the configured size to the store depth
	always_comb begin
		size_ext = SW'(set_size_q);
		if (size_ext > SW'(POOL_DEPTH))
			fill_n = CW'(POOL_DEPTH);
		else
			fill_n = CW'(size_ext);
	end

	assign last_cnt = count_q - 1'b1;
	assign trial    = {rem_q, dividend_q[RND_W-1]};
	assign trial_ge = trial >= {1'b0, count_q};

	always_comb begin
		mem_we = cmd.fill_step | cmd.swap;
		mem_wa = cmd.swap ? rem_q[AW-1:0] : fill_cnt_q[AW-1:0];
		mem_wd = cmd.swap ? rd_data_q : fill_cnt_q[AW-1:0];
		mem_re = cmd.rd_slot | cmd.rd_last;
		mem_ra = cmd.rd_last ? last_cnt[AW-1:0] : rem_q[AW-1:0];
	end

	always_comb begin
		sts.fill_done  = fill_cnt_q == fill_n;
		sts.count_zero = count_q == '0;
		sts.div_last   = div_cnt_q == DIVC_W'(RND_W - 1);
		sts.out_busy   = out_valid_q & ~m_ready;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_data_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q  <= '0;
			count_q     <= '0;
			fill_cnt_q  <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				set_size_q <= cfg_wr_data;
			if (cmd.restart)
				fill_cnt_q <= '0;
			else if (cmd.fill_step)
				fill_cnt_q <= fill_cnt_q + 1'b1;
			if (cmd.fill_end)
				count_q <= fill_n;
			else if (cmd.swap)
				count_q <= last_cnt;
			if (cmd.div_start)
				div_cnt_q <= '0;
			else if (cmd.div_step)
				div_cnt_q <= div_cnt_q + 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_ready)
				out_valid_q <= 1'b0;
		end
	end

	// restoring modulo, one dividend bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.load_in)
			dividend_q <= random_value;
		else if (cmd.div_step)
			dividend_q <= {dividend_q[RND_W-2:0], 1'b0};
		if (cmd.div_start)
			rem_q <= '0;
		else if (cmd.div_step)
			rem_q <= trial_ge ? CW'(trial - {1'b0, count_q}) : CW'(trial);
		if (cmd.rd_last)
			drawn_q <= rd_data_q;
		if (cmd.out_load) begin
			out_drawn_q <= cmd.out_exh ? '0 : DRAWN_W'(drawn_q);
			out_exh_q   <= cmd.out_exh;
		end
	end

	assign m_valid      = out_valid_q;
	assign drawn_number = out_drawn_q;
	assign exhausted    = out_exh_q;

	`URDP_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(POOL_DEPTH), "count above depth")
	`URDP_ASSERT_NOW(a_slot_live, cmd.rd_slot, rem_q < count_q, "slot outside live entries")
	`URDP_ASSERT_NEXT(a_swap_dec, cmd.swap, count_q == CW'($past(count_q) - 1'b1),
		"swap did not decrement count")

endmodule

`default_nettype wire

### rtl/urdp_ctrl.sv
// controller state machine sequencing restart fill, modulo, read and swap
// depends on urdp_pkg and the assertion macro header
`default_nettype none
`include "unique_random_draw_pool_unit_defines.svh"

module urdp_ctrl import urdp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_valid,
	input  wire logic      s_command,
	output logic           s_ready,
	input  wire urdp_sts_t sts,
	output urdp_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_CHECK,
		ST_DIV,
		ST_RD_SLOT,
		ST_RD_LAST,
		ST_SWAP,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   exh_q;

	always_comb begin
		cmd           = '0;
		cmd.out_exh   = exh_q;
		s_ready       = state_q == ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_in = s_valid;
				cmd.restart = s_valid & (s_command == CMD_RESTART);
			end
			ST_FILL: begin
				cmd.fill_step = ~sts.fill_done;
				cmd.fill_end  = sts.fill_done;
			end
			ST_CHECK:   cmd.div_start = ~sts.count_zero;
			ST_DIV:     cmd.div_step  = 1'b1;
			ST_RD_SLOT: cmd.rd_slot   = 1'b1;
			ST_RD_LAST: cmd.rd_last   = 1'b1;
			ST_SWAP:    cmd.swap      = 1'b1;
			ST_DONE:    cmd.out_load  = ~sts.out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			exh_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE:
					if (s_valid)
						state_q <= (s_command == CMD_RESTART) ? ST_FILL : ST_CHECK;
				ST_FILL:
					if (sts.fill_done)
						state_q <= ST_CHECK;
				ST_CHECK: begin
					exh_q   <= sts.count_zero;
					state_q <= sts.count_zero ? ST_DONE : ST_DIV;
				end
				ST_DIV:
					if (sts.div_last)
						state_q <= ST_RD_SLOT;
				ST_RD_SLOT: state_q <= ST_RD_LAST;
				ST_RD_LAST: state_q <= ST_SWAP;
				ST_SWAP:    state_q <= ST_DONE;
				ST_DONE:
					if (!sts.out_busy)
						state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`URDP_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second request taken early")
	`URDP_ASSERT_NEXT(a_div_to_read, cmd.div_step && sts.div_last, cmd.rd_slot,
		"modulo end not followed by slot read")
	`URDP_ASSERT_NEXT(a_swap_not_exh, cmd.swap, !exh_q, "draw marked exhausted")

endmodule

`default_nettype wire

### rtl/unique_random_draw_pool_unit.sv
// top level of the unique random draw pool: stream ports, config register port
// depends on urdp_pkg, urdp_ctrl and urdp_datapath
`default_nettype none

// Draws each number 0..n-1 once, in the order picked by the supplied random
// values (incremental Fisher-Yates). One request is worked on at a time; a
// finished result waits in an output register while the next request is taken.
// A draw checks for an empty pool, runs the bit-serial modulo of the 31-bit
// random value by the remaining count, reads the picked slot and the last live
// entry of the pool memory, writes that last entry into the picked slot, and
// loads the result, waiting while the output register still holds a result
// that is not yet taken. A restart request first fills entries 0..n-1 of the
// pool memory with the identity sequence, one entry a cycle, n being the
// configured set size capped at POOL_DEPTH. A request on an empty pool goes
// from the check straight to the result load, with exhausted set and a zero number.

module unique_random_draw_pool_unit import urdp_pkg::*; #(
	parameter int POOL_DEPTH = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [CFG_W-1:0]   cfg_wr_data,    // set size
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [31:0]        s_axis_tdata,   // random_value[30:0], zero
	input  wire logic [0:0]         s_axis_tuser,   // command
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [15:0]             m_axis_tdata,   // drawn_number[11:0], zero
	output logic [0:0]              m_axis_tuser    // exhausted
);

	urdp_cmd_t          cmd;
	urdp_sts_t          sts;
	logic [DRAWN_W-1:0] drawn_number;
	logic               exhausted;

	urdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_axis_tvalid),
		.s_command (s_axis_tuser[0]),
		.s_ready   (s_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	urdp_datapath #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_data  (cfg_wr_data),
		.cfg_wr_en    (cfg_wr_en),
		.random_value (s_axis_tdata[RND_W-1:0]),
		.cmd          (cmd),
		.sts          (sts),
		.m_ready      (m_axis_tready),
		.m_valid      (m_axis_tvalid),
		.drawn_number (drawn_number),
		.exhausted    (exhausted)
	);

	assign m_axis_tdata = {4'b0, drawn_number};
	assign m_axis_tuser = exhausted;

endmodule

`default_nettype wire
